// ----- rtl/gradient_noise_3d_octaves_unit_macros.svh -----
// Assertion macros shared by the noise unit RTL.
`ifndef GRADIENT_NOISE_3D_OCTAVES_UNIT_MACROS_SVH
`define GRADIENT_NOISE_3D_OCTAVES_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GN3O_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GN3O_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gn3o_pkg.sv -----
// Shared constants and types of the gradient noise unit.
`timescale 1ns / 1ps

package gn3o_pkg;

    localparam int FRAC    = 16;
    localparam int TAB_AW  = 8;
    localparam int TAB_DEPTH = 256;
    localparam int MAX_OCT = 16;
    localparam int OCT_W   = 4;
    localparam int COORD_W = 32;
    localparam int OP_W    = 24;
    localparam int PROD_W  = 2 * OP_W;
    localparam int ACC_W   = 48;
    localparam int AMP_W   = FRAC + 1;
    localparam int ASUM_W  = AMP_W + OCT_W;
    localparam int OUT_W   = 18;
    localparam int CFG_W   = 16;
    localparam int CFG_IW  = 1;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_EVAL3 = 2'd1;
    localparam logic [1:0] ACT_OCT   = 2'd2;

    localparam logic [CFG_IW-1:0] REG_OCTAVES = 1'b0;
    localparam logic [CFG_IW-1:0] REG_PERSIST = 1'b1;

    localparam logic signed [OP_W-1:0] ONE_FX     = OP_W'(1 << FRAC);
    localparam logic signed [OP_W-1:0] TEN_FX     = OP_W'(10 << FRAC);
    localparam logic signed [OP_W-1:0] FIFTEEN_FX = OP_W'(15 << FRAC);
    localparam logic [AMP_W-1:0]       AMP_ONE    = AMP_W'(1 << FRAC);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef logic signed [OP_W-1:0] op_t;

endpackage

// ----- rtl/gn3o_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gn3o_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/gn3o_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module gn3o_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [gn3o_pkg::OP_W-1:0]    a,
    input  logic signed [gn3o_pkg::OP_W-1:0]    b,
    output logic signed [gn3o_pkg::PROD_W-1:0]  p
);

    logic signed [gn3o_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/gn3o_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
`timescale 1ns / 1ps

module gn3o_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gn3o_pkg::ACC_W-1:0]   dividend,
    input  logic [gn3o_pkg::ASUM_W-1:0]         divisor,
    output logic                                done,
    output logic signed [gn3o_pkg::ACC_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(gn3o_pkg::ACC_W);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               neg_reg, neg_next;
    logic [gn3o_pkg::ASUM_W:0]          rem_reg, rem_next;
    logic [gn3o_pkg::ACC_W-1:0]         q_reg, q_next;
    logic [gn3o_pkg::ASUM_W:0]          rem_sh;
    logic                               fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        rem_sh    = {rem_reg[gn3o_pkg::ASUM_W-1:0], q_reg[gn3o_pkg::ACC_W-1]};
        fits      = (rem_sh >= {1'b0, divisor});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[gn3o_pkg::ACC_W-1];
            rem_next  = '0;
            q_next    = dividend[gn3o_pkg::ACC_W-1] ? -dividend : dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
            q_next   = {q_reg[gn3o_pkg::ACC_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(gn3o_pkg::ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(q_reg) : signed'(q_reg);

endmodule

// ----- rtl/gradient_noise_3d_octaves_unit.sv -----
// Top level of the fixed-point improved gradient noise unit with octave summing.
//
// Usage. Items arrive on the input channel (in_valid, in_stall) and results leave on
// the output channel (out_valid, out_stall); a transfer happens at a rising edge where
// valid is high and stall is low. A load item writes one byte of the 256-entry
// permutation table in the cycle of its transfer and gives no result. An evaluate item
// gives one Q1.16 noise value; an octave item sums octave_count 2D octaves (one if zero,
// at most 16) at z = 0 and divides by the summed amplitude. Action code 3 is dropped
// without a result. The unit works on one item at a time. A 3D evaluation makes 14
// table reads, each an address step and a data step, through the single read port of
// the table, then 19 multiply and write-back steps on the one shared multiplier, and
// then loads the output register. An octave item makes 14 table reads and 21 multiply
// steps per octave, followed by the final bit-serial division.
// The result waits in an output register, so the next item may be transferred while it
// is held; if the receiver stalls, the unit finishes its next result and then waits.
// Reset clears the control state and sets the configuration registers (four octaves, persistence 0.5);
// the table is not cleared and must be written before it is used.
// Configuration writes are taken at any cycle with cfg_write high and are meant for idle.
`timescale 1ns / 1ps
`include "gradient_noise_3d_octaves_unit_macros.svh"

module gradient_noise_3d_octaves_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              action,
    input  logic [gn3o_pkg::TAB_AW-1:0]             table_index,
    input  logic [gn3o_pkg::TAB_AW-1:0]             table_value,
    input  logic signed [gn3o_pkg::COORD_W-1:0]     coord_x,
    input  logic signed [gn3o_pkg::COORD_W-1:0]     coord_y,
    input  logic signed [gn3o_pkg::COORD_W-1:0]     coord_z,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [gn3o_pkg::OUT_W-1:0]       noise_value,
    input  logic                                    cfg_write,
    input  logic [gn3o_pkg::CFG_IW-1:0]             cfg_index,
    input  logic [gn3o_pkg::CFG_W-1:0]              cfg_data
);

    localparam int FR = gn3o_pkg::FRAC;
    localparam int AW = gn3o_pkg::TAB_AW;
    localparam int OW = gn3o_pkg::OP_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD_ADDR = 3'd1;
    localparam logic [2:0] S_RD_DATA = 3'd2;
    localparam logic [2:0] S_MUL     = 3'd3;
    localparam logic [2:0] S_WB      = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // Table read steps: the two x lookups, the four y/z hashes, then eight corners.
    localparam logic [3:0] RD_XA    = 4'd0;
    localparam logic [3:0] RD_XB    = 4'd1;
    localparam logic [3:0] RD_AA    = 4'd2;
    localparam logic [3:0] RD_AB    = 4'd3;
    localparam logic [3:0] RD_BA    = 4'd4;
    localparam logic [3:0] RD_BB    = 4'd5;
    localparam logic [3:0] RD_CORN  = 4'd6;
    localparam logic [3:0] RD_LAST  = 4'd13;

    // Multiply steps: 0 to 11 are the three fade curves, four steps per axis.
    localparam logic [4:0] U_MIX0   = 5'd12;
    localparam logic [4:0] U_MIX1   = 5'd13;
    localparam logic [4:0] U_MIX2   = 5'd14;
    localparam logic [4:0] U_MIX3   = 5'd15;
    localparam logic [4:0] U_MIXY0  = 5'd16;
    localparam logic [4:0] U_MIXY1  = 5'd17;
    localparam logic [4:0] U_MIXZ   = 5'd18;
    localparam logic [4:0] U_ACC    = 5'd19;
    localparam logic [4:0] U_AMP    = 5'd20;

    localparam logic [1:0] K_INNER  = 2'd0;
    localparam logic [1:0] K_SQ     = 2'd1;
    localparam logic [1:0] K_CUBE   = 2'd2;

    function automatic gn3o_pkg::op_t grad_dot(input logic [3:0] k, input gn3o_pkg::op_t dx,
                                               input gn3o_pkg::op_t dy, input gn3o_pkg::op_t dz);
        gn3o_pkg::op_t first;
        gn3o_pkg::op_t second;
        gn3o_pkg::op_t fs;
        gn3o_pkg::op_t ss;
        first  = (k < 4'd8) ? dx : dy;
        second = (k < 4'd4) ? dy : ((k == 4'd12 || k == 4'd14) ? dx : dz);
        fs     = k[0] ? -first : first;
        ss     = k[1] ? -second : second;
        return fs + ss;
    endfunction

    function automatic logic signed [gn3o_pkg::OUT_W-1:0] saturate(
        input logic signed [gn3o_pkg::ACC_W-1:0] v);
        logic signed [gn3o_pkg::ACC_W-1:0] c;
        c = v;
        if (v > gn3o_pkg::SAT_HI)
        begin
            c = gn3o_pkg::SAT_HI;
        end
        if (v < gn3o_pkg::SAT_LO)
        begin
            c = gn3o_pkg::SAT_LO;
        end
        return c[gn3o_pkg::OUT_W-1:0];
    endfunction

    logic [2:0]                             state_reg, state_next;
    logic                                   oct_mode_reg, oct_mode_next;
    logic [gn3o_pkg::COORD_W-1:0]           cx_reg, cx_next;
    logic [gn3o_pkg::COORD_W-1:0]           cy_reg, cy_next;
    logic [gn3o_pkg::COORD_W-1:0]           cz_reg, cz_next;
    logic [3:0]                             rd_reg, rd_next;
    logic [4:0]                             uop_reg, uop_next;
    logic [gn3o_pkg::OCT_W-1:0]             oct_reg, oct_next;
    logic [gn3o_pkg::OCT_W-1:0]             oct_last_reg, oct_last_next;
    logic [AW-1:0]                          ha_reg, ha_next;
    logic [AW-1:0]                          hb_reg, hb_next;
    logic [AW-1:0]                          hxy_reg [4];
    logic [AW-1:0]                          hxy_next [4];
    gn3o_pkg::op_t                          grad_reg [8];
    gn3o_pkg::op_t                          grad_next [8];
    gn3o_pkg::op_t                          fade_reg [3];
    gn3o_pkg::op_t                          fade_next [3];
    gn3o_pkg::op_t                          mix_reg [7];
    gn3o_pkg::op_t                          mix_next [7];
    gn3o_pkg::op_t                          inner_reg, inner_next;
    gn3o_pkg::op_t                          sq_reg, sq_next;
    gn3o_pkg::op_t                          cube_reg, cube_next;
    logic signed [gn3o_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [gn3o_pkg::ASUM_W-1:0]            asum_reg, asum_next;
    logic [gn3o_pkg::AMP_W-1:0]             amp_reg, amp_next;
    logic [4:0]                             octave_count_reg, octave_count_next;
    logic [gn3o_pkg::CFG_W-1:0]             persistence_reg, persistence_next;
    logic signed [gn3o_pkg::OUT_W-1:0]      res_reg, res_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [gn3o_pkg::OUT_W-1:0]      noise_reg, noise_next;

    logic                                   in_xfer;
    logic                                   ram_we;
    logic                                   ram_re;
    logic [AW-1:0]                          ram_raddr;
    logic [AW-1:0]                          ram_q;
    logic [2:0]                             corner;
    logic [1:0]                             axis;
    gn3o_pkg::op_t                          fx, fy, fz, gx, gy, gz, t_sel;
    gn3o_pkg::op_t                          mul_a, mul_b, prod_sh;
    logic signed [gn3o_pkg::PROD_W-1:0]     mul_p;
    logic signed [gn3o_pkg::PROD_W-1:0]     prod_shift;
    logic                                   div_start;
    logic                                   div_done;
    logic signed [gn3o_pkg::ACC_W-1:0]      div_q;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // Offsets within the cell and their complements (offset minus one).
    assign fx = signed'({{(OW - FR){1'b0}}, cx_reg[FR-1:0]});
    assign fy = signed'({{(OW - FR){1'b0}}, cy_reg[FR-1:0]});
    assign fz = signed'({{(OW - FR){1'b0}}, cz_reg[FR-1:0]});
    assign gx = fx - gn3o_pkg::ONE_FX;
    assign gy = fy - gn3o_pkg::ONE_FX;
    assign gz = fz - gn3o_pkg::ONE_FX;

    assign corner = rd_reg[2:0] - RD_CORN[2:0];
    assign axis   = uop_reg[3:2];

    // Table read address for the current read step.
    always_comb
    begin
        case (rd_reg)
            RD_XA:   ram_raddr = cx_reg[FR+AW-1:FR];
            RD_XB:   ram_raddr = cx_reg[FR+AW-1:FR] + 1'b1;
            RD_AA:   ram_raddr = ha_reg;
            RD_AB:   ram_raddr = ha_reg + 1'b1;
            RD_BA:   ram_raddr = hb_reg;
            RD_BB:   ram_raddr = hb_reg + 1'b1;
            default: ram_raddr = hxy_reg[corner[1:0]] + AW'(corner[2]);
        endcase
    end

    assign ram_we = in_xfer && (action == gn3o_pkg::ACT_LOAD);
    assign ram_re = (state_reg == S_RD_ADDR);

    gn3o_ram #(
        .WIDTH (AW),
        .DEPTH (gn3o_pkg::TAB_DEPTH)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (table_index),
        .wdata (table_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (axis)
            2'd0:    t_sel = fx;
            2'd1:    t_sel = fy;
            default: t_sel = fz;
        endcase
        case (uop_reg)
            U_MIX0:
            begin
                mul_a = fade_reg[0];
                mul_b = grad_reg[1] - grad_reg[0];
            end
            U_MIX1:
            begin
                mul_a = fade_reg[0];
                mul_b = grad_reg[3] - grad_reg[2];
            end
            U_MIX2:
            begin
                mul_a = fade_reg[0];
                mul_b = grad_reg[5] - grad_reg[4];
            end
            U_MIX3:
            begin
                mul_a = fade_reg[0];
                mul_b = grad_reg[7] - grad_reg[6];
            end
            U_MIXY0:
            begin
                mul_a = fade_reg[1];
                mul_b = mix_reg[1] - mix_reg[0];
            end
            U_MIXY1:
            begin
                mul_a = fade_reg[1];
                mul_b = mix_reg[3] - mix_reg[2];
            end
            U_MIXZ:
            begin
                mul_a = fade_reg[2];
                mul_b = mix_reg[5] - mix_reg[4];
            end
            U_ACC:
            begin
                mul_a = mix_reg[6];
                mul_b = signed'({{(OW - gn3o_pkg::AMP_W){1'b0}}, amp_reg});
            end
            U_AMP:
            begin
                mul_a = signed'({{(OW - gn3o_pkg::AMP_W){1'b0}}, amp_reg});
                mul_b = signed'({{(OW - gn3o_pkg::CFG_W){1'b0}}, persistence_reg});
            end
            default:
            begin
                // Fade curve 6t^5 - 15t^4 + 10t^3, built from four products.
                case (uop_reg[1:0])
                    K_INNER:
                    begin
                        mul_a = t_sel;
                        mul_b = (t_sel <<< 2) + (t_sel <<< 1) - gn3o_pkg::FIFTEEN_FX;
                    end
                    K_SQ:
                    begin
                        mul_a = t_sel;
                        mul_b = t_sel;
                    end
                    K_CUBE:
                    begin
                        mul_a = sq_reg;
                        mul_b = t_sel;
                    end
                    default:
                    begin
                        mul_a = cube_reg;
                        mul_b = inner_reg;
                    end
                endcase
            end
        endcase
    end

    gn3o_mul u_mul (
        .clk (clk),
        .en  (state_reg == S_MUL),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign prod_shift = mul_p >>> FR;
    assign prod_sh    = prod_shift[OW-1:0];

    gn3o_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (asum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer and datapath register updates.
    always_comb
    begin
        state_next        = state_reg;
        oct_mode_next     = oct_mode_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        cz_next           = cz_reg;
        rd_next           = rd_reg;
        uop_next          = uop_reg;
        oct_next          = oct_reg;
        oct_last_next     = oct_last_reg;
        ha_next           = ha_reg;
        hb_next           = hb_reg;
        hxy_next          = hxy_reg;
        grad_next         = grad_reg;
        fade_next         = fade_reg;
        mix_next          = mix_reg;
        inner_next        = inner_reg;
        sq_next           = sq_reg;
        cube_next         = cube_reg;
        acc_next          = acc_reg;
        asum_next         = asum_reg;
        amp_next          = amp_reg;
        octave_count_next = octave_count_reg;
        persistence_next  = persistence_reg;
        res_next          = res_reg;
        noise_next        = noise_reg;
        out_valid_next    = out_valid_reg && out_stall;
        div_start         = 1'b0;

        if (cfg_write)
        begin
            if (cfg_index == gn3o_pkg::REG_OCTAVES)
            begin
                octave_count_next = cfg_data[4:0];
            end
            else
            begin
                persistence_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cx_next = coord_x;
                    cy_next = coord_y;
                    cz_next = coord_z;
                    rd_next = RD_XA;
                    uop_next = '0;
                    oct_next = '0;
                    acc_next = '0;
                    asum_next = '0;
                    amp_next = gn3o_pkg::AMP_ONE;
                    if (octave_count_reg == 5'd0)
                    begin
                        oct_last_next = '0;
                    end
                    else if (octave_count_reg > 5'(gn3o_pkg::MAX_OCT))
                    begin
                        oct_last_next = gn3o_pkg::OCT_W'(gn3o_pkg::MAX_OCT - 1);
                    end
                    else
                    begin
                        oct_last_next = gn3o_pkg::OCT_W'(octave_count_reg - 5'd1);
                    end
                    if (action == gn3o_pkg::ACT_EVAL3)
                    begin
                        oct_mode_next = 1'b0;
                        state_next = S_RD_ADDR;
                    end
                    else if (action == gn3o_pkg::ACT_OCT)
                    begin
                        oct_mode_next = 1'b1;
                        cz_next = '0;
                        state_next = S_RD_ADDR;
                    end
                end
            end
            S_RD_ADDR:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                case (rd_reg)
                    RD_XA:   ha_next = ram_q + cy_reg[FR+AW-1:FR];
                    RD_XB:   hb_next = ram_q + cy_reg[FR+AW-1:FR];
                    RD_AA:   hxy_next[0] = ram_q + cz_reg[FR+AW-1:FR];
                    RD_AB:   hxy_next[2] = ram_q + cz_reg[FR+AW-1:FR];
                    RD_BA:   hxy_next[1] = ram_q + cz_reg[FR+AW-1:FR];
                    RD_BB:   hxy_next[3] = ram_q + cz_reg[FR+AW-1:FR];
                    default: grad_next[corner] = grad_dot(ram_q[3:0],
                                                          corner[0] ? gx : fx,
                                                          corner[1] ? gy : fy,
                                                          corner[2] ? gz : fz);
                endcase
                rd_next = rd_reg + 1'b1;
                state_next = (rd_reg == RD_LAST) ? S_MUL : S_RD_ADDR;
            end
            S_MUL:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                uop_next = uop_reg + 1'b1;
                state_next = S_MUL;
                case (uop_reg)
                    U_MIX0:  mix_next[0] = grad_reg[0] + prod_sh;
                    U_MIX1:  mix_next[1] = grad_reg[2] + prod_sh;
                    U_MIX2:  mix_next[2] = grad_reg[4] + prod_sh;
                    U_MIX3:  mix_next[3] = grad_reg[6] + prod_sh;
                    U_MIXY0: mix_next[4] = mix_reg[0] + prod_sh;
                    U_MIXY1: mix_next[5] = mix_reg[2] + prod_sh;
                    U_MIXZ:
                    begin
                        mix_next[6] = mix_reg[4] + prod_sh;
                        if (!oct_mode_reg)
                        begin
                            res_next = saturate(gn3o_pkg::ACC_W'(mix_reg[4] + prod_sh));
                            state_next = S_DONE;
                        end
                    end
                    U_ACC:
                    begin
                        acc_next = acc_reg + mul_p;
                        asum_next = asum_reg + gn3o_pkg::ASUM_W'(amp_reg);
                    end
                    U_AMP:
                    begin
                        amp_next = mul_p[FR+gn3o_pkg::AMP_W-1:FR];
                        if (oct_reg == oct_last_reg)
                        begin
                            div_start = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            // Next octave: double the frequency by shifting the point.
                            oct_next = oct_reg + 1'b1;
                            cx_next = {cx_reg[gn3o_pkg::COORD_W-2:0], 1'b0};
                            cy_next = {cy_reg[gn3o_pkg::COORD_W-2:0], 1'b0};
                            rd_next = RD_XA;
                            uop_next = '0;
                            state_next = S_RD_ADDR;
                        end
                    end
                    default:
                    begin
                        case (uop_reg[1:0])
                            K_INNER: inner_next = prod_sh + gn3o_pkg::TEN_FX;
                            K_SQ:    sq_next = prod_sh;
                            K_CUBE:  cube_next = prod_sh;
                            default: fade_next[axis] = prod_sh;
                        endcase
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next = saturate(div_q);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    noise_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            octave_count_reg <= 5'd4;
            persistence_reg  <= gn3o_pkg::CFG_W'(32768);
            oct_mode_reg     <= 1'b0;
            rd_reg           <= '0;
            uop_reg          <= '0;
            oct_reg          <= '0;
            oct_last_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            octave_count_reg <= octave_count_next;
            persistence_reg  <= persistence_next;
            oct_mode_reg     <= oct_mode_next;
            rd_reg           <= rd_next;
            uop_reg          <= uop_next;
            oct_reg          <= oct_next;
            oct_last_reg     <= oct_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        ha_reg    <= ha_next;
        hb_reg    <= hb_next;
        hxy_reg   <= hxy_next;
        grad_reg  <= grad_next;
        fade_reg  <= fade_next;
        mix_reg   <= mix_next;
        inner_reg <= inner_next;
        sq_reg    <= sq_next;
        cube_reg  <= cube_next;
        acc_reg   <= acc_next;
        asum_reg  <= asum_next;
        amp_reg   <= amp_next;
        res_reg   <= res_next;
        noise_reg <= noise_next;
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    // A multiply step is always followed by its write-back.
    `GN3O_ASSERT_NXT(a_mul_then_wb, clk, rst_n, state_reg == S_MUL, state_reg == S_WB, "no write-back")
    // The divider only finishes while the sequencer waits for it.
    `GN3O_ASSERT_IMP(a_div_done_waited, clk, rst_n, div_done, state_reg == S_DIV, "stray divide")
    // A finished result with a free output register is presented in the next cycle.
    `GN3O_ASSERT_NXT(a_done_presents, clk, rst_n, state_reg == S_DONE && !out_valid_reg, out_valid_reg && state_reg == S_IDLE, "not presented")

endmodule
